[hw/rtl/tpsm_pkg.sv]
// Shared constants and the request token type for the palette symbol mapper.
`timescale 1ns / 1ps
`default_nettype none

package tpsm_pkg;

	localparam int unsigned PaletteEntries = 94;
	localparam int unsigned ChanW          = 8;
	localparam int unsigned CodeW          = 7;

	localparam logic [ChanW-1:0] ToleranceReset = 8'd40;
	localparam logic [CodeW-1:0] CodeBase       = 7'd33;
	localparam logic [CodeW-1:0] CodeSpace      = 7'd32;

	typedef struct packed {
		logic             valid;
		logic             matched;
		logic             new_entry;
		logic [CodeW-1:0] code;
		logic [ChanW-1:0] blue;
		logic [ChanW-1:0] green;
		logic [ChanW-1:0] red;
	} token_t;

endpackage

`default_nettype wire

[hw/rtl/tpsm_cell.sv]
// One palette cell: holds one color, matches or claims the passing request.
`timescale 1ns / 1ps
`default_nettype none

module tpsm_cell #(
	parameter int unsigned CellIdx = 0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [tpsm_pkg::ChanW-1:0] tolerance,
	input  wire tpsm_pkg::token_t           tok_i,
	output tpsm_pkg::token_t                tok_o,
	output logic                            entry_valid
);

	import tpsm_pkg::*;

	localparam logic [CodeW-1:0] CellCode = CodeW'(CellIdx) + CodeBase;

	logic              valid_q;
	logic [ChanW-1:0]  blue_q;
	logic [ChanW-1:0]  green_q;
	logic [ChanW-1:0]  red_q;
	token_t            tok_q;
	token_t            tok_d;
	logic              close;
	logic              claim;

	function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
	                                              input logic [ChanW-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	assign close = (abs_diff(blue_q, tok_i.blue) <= tolerance)
	            && (abs_diff(green_q, tok_i.green) <= tolerance)
	            && (abs_diff(red_q, tok_i.red) <= tolerance);

	assign claim = tok_i.valid && !tok_i.matched && !valid_q;

	always_comb begin
		tok_d = tok_i;
		if (tok_i.valid && !tok_i.matched) begin
			if (valid_q && close) begin
				tok_d.matched = 1'b1;
				tok_d.code    = CellCode;
			end else if (!valid_q) begin
				tok_d.matched   = 1'b1;
				tok_d.new_entry = 1'b1;
				tok_d.code      = CellCode;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_d;
			if (claim) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			blue_q  <= tok_i.blue;
			green_q <= tok_i.green;
			red_q   <= tok_i.red;
		end
	end

	assign tok_o       = tok_q;
	assign entry_valid = valid_q;

endmodule

`default_nettype wire

[hw/rtl/tolerance_palette_symbol_mapper.sv]
// Top level: tolerance register and the chain of palette cells.
//
// Usage:
//   A pixel request (blue, green, red) is taken at a rising edge with start
//   high and busy low. busy stays low: a new pixel enters the chain every cycle.
//   Each request walks the row of PALETTE_ENTRIES cells, one cell per cycle.
//   Each cell either matches the pixel within the tolerance, claims the pixel
//   as a new color if the cell is still empty, or passes it on. The first
//   empty cell is the next fill slot, so lower entries always win.
//   Results: strobe is high for one cycle with char_code and new_entry,
//   once the request has passed the register of every cell; char_code is 32 when no
//   cell matched and the palette is full. Results come out in request order.
//   Throughput is one pixel per cycle; latency is set by the chain length.
//   The receiver cannot stall; results must be taken as they appear.
//   tolerance_we writes tolerance (reset 40); write only while no request is
//   in flight.
//   Reset clears all cell valid bits (empty palette) and in-flight requests.
`timescale 1ns / 1ps
`default_nettype none

module tolerance_palette_symbol_mapper #(
	parameter int unsigned PALETTE_ENTRIES = tpsm_pkg::PaletteEntries
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [tpsm_pkg::ChanW-1:0] blue,
	input  wire logic [tpsm_pkg::ChanW-1:0] green,
	input  wire logic [tpsm_pkg::ChanW-1:0] red,
	input  wire logic                       tolerance_we,
	input  wire logic [tpsm_pkg::ChanW-1:0] tolerance_wdata,
	output logic                            strobe,
	output logic [tpsm_pkg::CodeW-1:0]      char_code,
	output logic                            new_entry
);

	import tpsm_pkg::*;

	logic [ChanW-1:0]           tolerance_q;
	token_t                     tok [PALETTE_ENTRIES+1];
	logic [PALETTE_ENTRIES-1:0] entry_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= ToleranceReset;
		end else if (tolerance_we) begin
			tolerance_q <= tolerance_wdata;
		end
	end

	assign busy = 1'b0;

	always_comb begin
		tok[0]           = '0;
		tok[0].valid     = start && !busy;
		tok[0].blue      = blue;
		tok[0].green     = green;
		tok[0].red       = red;
	end

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		tpsm_cell #(
			.CellIdx(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.tolerance  (tolerance_q),
			.tok_i      (tok[i]),
			.tok_o      (tok[i+1]),
			.entry_valid(entry_vld[i])
		);
	end

	assign strobe    = tok[PALETTE_ENTRIES].valid;
	assign char_code = tok[PALETTE_ENTRIES].matched ? tok[PALETTE_ENTRIES].code : CodeSpace;
	assign new_entry = tok[PALETTE_ENTRIES].valid && tok[PALETTE_ENTRIES].new_entry;

	// filled cells always form a prefix of the chain
	a_fill_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((entry_vld >> 1) & ~entry_vld) == '0)
		else $error("palette fill is not contiguous");

	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_vld) >= $past($countones(entry_vld)))
		else $error("palette entry lost");

	a_new_has_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && new_entry) |-> (char_code != CodeSpace))
		else $error("new entry reported without a slot code");

	a_space_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && char_code == CodeSpace) |-> (&entry_vld))
		else $error("space emitted while palette has room");

endmodule

`default_nettype wire
